### sv/ptts_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and microcode for the periodic task tick scheduler.
// No dependencies; every other file imports this package.
package ptts_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FIELD_W     = 16;
  localparam int MASK_W      = 8;
  localparam int ASLOT_W     = 3;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [NUM_SLOTS-1:0]   slot_vec_t;
  typedef logic [SLOT_W-1:0]      slot_idx_t;
  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [MASK_W-1:0]      mask_t;
  typedef logic [ASLOT_W-1:0]     aslot_t;

  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_CREATE = 1'b1;

  typedef logic [1:0] step_t;
  localparam step_t STEP_FETCH  = 2'd0;
  localparam step_t STEP_TICK   = 2'd1;
  localparam step_t STEP_CREATE = 2'd2;
  localparam step_t STEP_SPARE  = 2'd3;

  typedef enum logic [1:0] {
    JMP_ALWAYS,
    JMP_DISPATCH,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic  accept;
    logic  op_tick;
    logic  op_create;
    jmp_t  jmp;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic tick;
    logic create;
  } bank_ctl_t;

  typedef struct packed {
    slot_vec_t fired;
    slot_idx_t slot;
    logic      full;
  } bank_res_t;

  function automatic uword_t urom(step_t s);
    uword_t w;
    case (s)
      STEP_FETCH:  w = '{accept: 1'b1, op_tick: 1'b0, op_create: 1'b0,
                         jmp: JMP_DISPATCH, target: STEP_FETCH};
      STEP_TICK:   w = '{accept: 1'b0, op_tick: 1'b1, op_create: 1'b0,
                         jmp: JMP_WAIT_OUT, target: STEP_FETCH};
      STEP_CREATE: w = '{accept: 1'b0, op_tick: 1'b0, op_create: 1'b1,
                         jmp: JMP_WAIT_OUT, target: STEP_FETCH};
      default:     w = '{accept: 1'b0, op_tick: 1'b0, op_create: 1'b0,
                         jmp: JMP_ALWAYS, target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

### sv/ptts_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on ptts_pkg.
module ptts_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_mode,
  input  logic               out_free,
  output logic               accept,
  output ptts_pkg::bank_ctl_t ctl
);
  import ptts_pkg::*;

  step_t  step_r, step_nxt;
  uword_t uw;

  assign uw     = urom(step_r);
  assign accept = uw.accept;

  always_comb begin
    case (uw.jmp)
      JMP_ALWAYS:   step_nxt = uw.target;
      JMP_DISPATCH: begin
        if (in_valid) begin
          step_nxt = (in_mode == MODE_CREATE) ? STEP_CREATE : STEP_TICK;
        end else begin
          step_nxt = step_r;
        end
      end
      JMP_WAIT_OUT: step_nxt = out_free ? uw.target : step_r;
      default:      step_nxt = STEP_FETCH;
    endcase
  end

  always_comb begin
    ctl.tick   = uw.op_tick & out_free;
    ctl.create = uw.op_create & out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### sv/ptts_bank.sv
`timescale 1ns / 1ps
// Slot bank: per-slot active bit, countdown and period cells, plus the
// lowest-free-slot priority chain. Depends on ptts_pkg.
module ptts_bank (
  input  logic                clk,
  input  logic                rst_n,
  input  ptts_pkg::bank_ctl_t ctl,
  input  ptts_pkg::cnt_t      delay,
  input  ptts_pkg::cnt_t      period,
  output ptts_pkg::bank_res_t res
);
  import ptts_pkg::*;

  slot_vec_t active_r;
  cnt_t      cnt_r [NUM_SLOTS];
  cnt_t      per_r [NUM_SLOTS];

  always_comb begin
    res.slot = '0;
    res.full = 1'b1;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        res.slot = SLOT_W'(i);
        res.full = 1'b0;
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      res.fired[i] = active_r[i] && (cnt_r[i] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (ctl.create && !res.full) begin
      active_r[res.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (ctl.tick && active_r[i]) begin
        cnt_r[i] <= (cnt_r[i] == '0) ? per_r[i] : cnt_r[i] - cnt_t'(1);
      end else if (ctl.create && !res.full && res.slot == SLOT_W'(i)) begin
        cnt_r[i] <= delay;
        per_r[i] <= period;
      end
    end
  end

endmodule

### sv/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// Periodic task tick scheduler: a bank of task slots driven by a small
// microcoded sequencer. Each item goes through a fetch step that accepts
// it and one execute step (tick all slots, or claim the lowest free slot)
// that writes the result register. The execute step waits only while the
// result register holds an item that has not been taken; a new item is
// accepted while a result is still waiting, but not while the execute step
// of the last item is pending. Depends on ptts_pkg, ptts_seq and ptts_bank.
module periodic_task_tick_scheduler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  ptts_pkg::field_t     in_start_delay,
  input  ptts_pkg::field_t     in_reload_period,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptts_pkg::mask_t      out_fired_mask,
  output ptts_pkg::aslot_t     out_assigned_slot,
  output logic                 out_table_full
);
  import ptts_pkg::*;

  logic      accept;
  logic      out_free;
  logic      load;
  bank_ctl_t ctl;
  bank_res_t res;

  cnt_t   delay_r, period_r;
  logic   out_valid_r;
  mask_t  mask_r, mask_nxt;
  aslot_t slot_r, slot_nxt;
  logic   full_r, full_nxt;

  logic [MASK_W+NUM_SLOTS-1:0] fired_ext;
  logic [ASLOT_W+SLOT_W-1:0]   slot_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !accept;
  assign load     = ctl.tick | ctl.create;

  ptts_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .out_free (out_free),
    .accept   (accept),
    .ctl      (ctl)
  );

  ptts_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .delay  (delay_r),
    .period (period_r),
    .res    (res)
  );

  assign fired_ext = {MASK_W'(0), res.fired};
  assign slot_ext  = {ASLOT_W'(0), res.slot};

  always_comb begin
    mask_nxt = '0;
    slot_nxt = '0;
    full_nxt = 1'b0;
    if (ctl.tick) begin
      mask_nxt = fired_ext[MASK_W-1:0];
    end
    if (ctl.create) begin
      full_nxt = res.full;
      slot_nxt = res.full ? '0 : slot_ext[ASLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && accept) begin
      delay_r  <= cnt_t'(in_start_delay);
      period_r <= cnt_t'(in_reload_period);
    end
    if (load) begin
      mask_r <= mask_nxt;
      slot_r <= slot_nxt;
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fired_mask    = mask_r;
  assign out_assigned_slot = slot_r;
  assign out_table_full    = full_r;

endmodule

### sv/ptts_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the periodic task tick scheduler, bound to the top.
// Depends on ptts_pkg and periodic_task_tick_scheduler.
module ptts_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input ptts_pkg::mask_t  out_fired_mask,
  input ptts_pkg::aslot_t out_assigned_slot,
  input logic             out_table_full
);
  import ptts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fired_mask)
      && $stable(out_assigned_slot) && $stable(out_table_full))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted during execute step");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fired_mask == '0
      || (out_assigned_slot == '0 && out_table_full == 1'b0))
    else $error("result mixes tick and create fields");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_assigned_slot == '0)
    else $error("full create reports a slot");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);
